[rtl/core/normal_latlong_encoder_assert.svh]
// Assertion shorthands, clocked on clk_i and idle while rst_ni is low.
`ifndef NORMAL_LATLONG_ENCODER_ASSERT_SVH
`define NORMAL_LATLONG_ENCODER_ASSERT_SVH

// Same-cycle implication.
`define NLLE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("nlle: same-cycle check failed");

// Next-cycle implication.
`define NLLE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("nlle: next-cycle check failed");

`endif

[rtl/core/nlle_pkg.sv]
package nlle_pkg;

  localparam int unsigned SqrtSteps = 31;

  // atan(2^-i) in binary angle units, 2^32 per turn
  localparam logic [31:0] AtanTable [32] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  typedef struct packed {
    logic tiny;
    logic xneg;
    logic yneg;
    logic zneg;
  } ctl_t;

  typedef struct packed {
    logic [60:0] rem;
    logic [60:0] root;
    logic [30:0] mz;
    logic [31:0] ax;
    logic [31:0] ay;
    ctl_t        ctl;
  } sq_t;

  typedef struct packed {
    logic signed [34:0] lat_x;
    logic signed [34:0] lat_y;
    logic signed [33:0] lat_a;
    logic signed [34:0] lng_x;
    logic signed [34:0] lng_y;
    logic signed [33:0] lng_a;
    ctl_t               ctl;
  } cd_t;

endpackage

[rtl/core/nlle_in_if.sv]
interface nlle_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] norm_x;
  logic signed [15:0] norm_y;
  logic signed [15:0] norm_z;

  modport source (output valid, output norm_x, output norm_y, output norm_z, input ready);
  modport sink (input valid, input norm_x, input norm_y, input norm_z, output ready);
endinterface

[rtl/core/nlle_out_if.sv]
interface nlle_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] encoded_normal;

  modport source (output valid, output encoded_normal, input ready);
  modport sink (input valid, input encoded_normal, output ready);
endinterface

[rtl/core/nlle_sqrt_stage.sv]
module nlle_sqrt_stage #(
  parameter int unsigned Step = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  nlle_pkg::sq_t data_i,
  output logic          valid_o,
  output nlle_pkg::sq_t data_o
);
  import nlle_pkg::*;

  localparam logic [60:0] BitVal = 61'(1) << (60 - 2 * Step);

  logic [61:0] trial;
  sq_t         data_d, data_q;
  logic        valid_q;

  always_comb begin
    trial  = {1'b0, data_i.root} + {1'b0, BitVal};
    data_d = data_i;
    if ({1'b0, data_i.rem} >= trial) begin
      data_d.rem  = data_i.rem - trial[60:0];
      data_d.root = (data_i.root >> 1) + BitVal;
    end else begin
      data_d.root = data_i.root >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

[rtl/core/nlle_cordic_stage.sv]
module nlle_cordic_stage #(
  parameter int unsigned Iter = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          en_i,
  input  logic          valid_i,
  input  nlle_pkg::cd_t data_i,
  output logic          valid_o,
  output nlle_pkg::cd_t data_o
);
  import nlle_pkg::*;

  localparam int unsigned Shift = Iter % 32;
  localparam logic signed [33:0] Step = $signed({2'b00, AtanTable[Shift]});

  cd_t  data_d, data_q;
  logic valid_q;

  // both lanes rotate y towards zero
  always_comb begin
    data_d = data_i;
    if (data_i.lat_y > 0) begin
      data_d.lat_x = data_i.lat_x + (data_i.lat_y >>> Shift);
      data_d.lat_y = data_i.lat_y - (data_i.lat_x >>> Shift);
      data_d.lat_a = data_i.lat_a + Step;
    end else begin
      data_d.lat_x = data_i.lat_x - (data_i.lat_y >>> Shift);
      data_d.lat_y = data_i.lat_y + (data_i.lat_x >>> Shift);
      data_d.lat_a = data_i.lat_a - Step;
    end
    if (data_i.lng_y > 0) begin
      data_d.lng_x = data_i.lng_x + (data_i.lng_y >>> Shift);
      data_d.lng_y = data_i.lng_y - (data_i.lng_x >>> Shift);
      data_d.lng_a = data_i.lng_a + Step;
    end else begin
      data_d.lng_x = data_i.lng_x - (data_i.lng_y >>> Shift);
      data_d.lng_y = data_i.lng_y + (data_i.lng_x >>> Shift);
      data_d.lng_a = data_i.lng_a - Step;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;
endmodule

[rtl/core/normal_latlong_encoder.sv]
// Normal to latitude/longitude code. Takes one vector a cycle while the output is not
// stalled and returns one 16-bit code per vector, latitude byte high, longitude byte low,
// 0 for a near-zero vector. The pipeline is 36 + ANGLE_ITERATIONS register stages deep.
// The stages are:
//   - three front stages: capture, squares and magnitudes, then the length test
//     and 1 - z^2;
//   - a 31-stage square-root pipeline at one root bit per stage;
//   - one stage per CORDIC iteration, with both angles worked side by side;
//   - an angle fold stage and the output register.
// The whole pipeline advances whenever the output register is free or being
// drained. A one-beat skid register at the input takes a vector while a result
// waits.
`include "normal_latlong_encoder_assert.svh"

module normal_latlong_encoder #(
  parameter int unsigned FRAC_BITS        = 14,
  parameter int unsigned ANGLE_ITERATIONS = 16
) (
  input  logic clk_i,
  input  logic rst_ni,
  nlle_in_if.sink    in_i,
  nlle_out_if.source out_o
);
  import nlle_pkg::*;

  localparam longint unsigned LenLim =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd9999) / 64'd10000;
  localparam logic [30:0] One = 31'(1) << FRAC_BITS;

  logic en;

  // input skid
  logic               skid_v_q, skid_v_d;
  logic signed [15:0] skid_x_q, skid_y_q, skid_z_q;

  // stage 1: captured vector
  logic               v1_q;
  logic signed [15:0] x1_q, y1_q, z1_q;

  // stage 2: squares, magnitudes
  logic        v2_q;
  logic [30:0] sqx_q, sqy_q, sqz_q;
  logic [31:0] ax2_q, ay2_q;
  logic [30:0] mz2_q;
  ctl_t        ctl2_q;
  logic [15:0] absx, absy, absz;
  logic [30:0] mzc;
  logic signed [31:0] sqx_s, sqy_s, sqz_s;

  // stage 3: length test, radicand
  logic        v3_q;
  sq_t         sq3_q;
  logic [32:0] sum2;
  logic [61:0] mzsq;

  // pipelines
  logic sq_v [SqrtSteps+1];
  sq_t  sq_d [SqrtSteps+1];
  logic cd_v [ANGLE_ITERATIONS+1];
  cd_t  cd_d [ANGLE_ITERATIONS+1];

  // fold stage
  logic        f_v_q;
  logic [32:0] f_lat_q, f_lat_d;
  logic [31:0] f_lng_q, f_lng_d;
  ctl_t        f_ctl_q;
  logic [30:0] a_lat, a_lng;

  // output
  logic        out_v_q;
  logic [15:0] out_code_q, out_code_d;
  logic [40:0] lat_prod, lng_prod;

  function automatic logic [30:0] clamp_ang(input logic signed [33:0] a);
    logic [30:0] r;
    if (a < 0) begin
      r = '0;
    end else if (a > 34'sd1073741824) begin
      r = 31'h4000_0000;
    end else begin
      r = a[30:0];
    end
    return r;
  endfunction

  assign en         = !out_v_q || out_o.ready;
  assign in_i.ready = !skid_v_q;

  always_comb begin
    skid_v_d = skid_v_q;
    if (en) begin
      skid_v_d = 1'b0;
    end else if (in_i.valid && !skid_v_q) begin
      skid_v_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      v1_q     <= 1'b0;
      v2_q     <= 1'b0;
      v3_q     <= 1'b0;
      f_v_q    <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      skid_v_q <= skid_v_d;
      if (en) begin
        v1_q    <= skid_v_q || in_i.valid;
        v2_q    <= v1_q;
        v3_q    <= v2_q;
        f_v_q   <= cd_v[ANGLE_ITERATIONS];
        out_v_q <= f_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_i.valid && !skid_v_q) begin
      skid_x_q <= in_i.norm_x;
      skid_y_q <= in_i.norm_y;
      skid_z_q <= in_i.norm_z;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      if (skid_v_q) begin
        x1_q <= skid_x_q;
        y1_q <= skid_y_q;
        z1_q <= skid_z_q;
      end else begin
        x1_q <= in_i.norm_x;
        y1_q <= in_i.norm_y;
        z1_q <= in_i.norm_z;
      end
    end
  end

  // stage 2
  always_comb begin
    absx  = x1_q[15] ? 16'(-x1_q) : x1_q;
    absy  = y1_q[15] ? 16'(-y1_q) : y1_q;
    absz  = z1_q[15] ? 16'(-z1_q) : z1_q;
    mzc   = ({15'b0, absz} > One) ? One : {15'b0, absz};
    sqx_s = x1_q * x1_q;
    sqy_s = y1_q * y1_q;
    sqz_s = z1_q * z1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sqx_q       <= sqx_s[30:0];
      sqy_q       <= sqy_s[30:0];
      sqz_q       <= sqz_s[30:0];
      ax2_q       <= {1'b0, absx, 15'b0};
      ay2_q       <= {1'b0, absy, 15'b0};
      mz2_q       <= 31'(mzc << (30 - FRAC_BITS));
      ctl2_q.tiny <= 1'b0;
      ctl2_q.xneg <= x1_q[15];
      ctl2_q.yneg <= y1_q[15];
      ctl2_q.zneg <= z1_q[15];
    end
  end

  // stage 3
  always_comb begin
    sum2 = {2'b0, sqx_q} + {2'b0, sqy_q} + {2'b0, sqz_q};
    mzsq = mz2_q * mz2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq3_q.rem  <= (61'(1) << 60) - mzsq[60:0];
      sq3_q.root <= '0;
      sq3_q.mz   <= mz2_q;
      sq3_q.ax   <= ax2_q;
      sq3_q.ay   <= ay2_q;
      sq3_q.ctl  <= '{tiny: (64'(sum2) < LenLim), xneg: ctl2_q.xneg,
                      yneg: ctl2_q.yneg, zneg: ctl2_q.zneg};
    end
  end

  assign sq_v[0] = v3_q;
  assign sq_d[0] = sq3_q;

  for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
    nlle_sqrt_stage #(.Step(g)) u_sqrt (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[g]),
      .data_i  (sq_d[g]),
      .valid_o (sq_v[g+1]),
      .data_o  (sq_d[g+1])
    );
  end

  always_comb begin
    cd_v[0]       = sq_v[SqrtSteps];
    cd_d[0].lat_x = $signed({3'b0, sq_d[SqrtSteps].ax});
    cd_d[0].lat_y = $signed({3'b0, sq_d[SqrtSteps].ay});
    cd_d[0].lat_a = '0;
    cd_d[0].lng_x = $signed({4'b0, sq_d[SqrtSteps].mz});
    cd_d[0].lng_y = $signed({4'b0, sq_d[SqrtSteps].root[30:0]});
    cd_d[0].lng_a = '0;
    cd_d[0].ctl   = sq_d[SqrtSteps].ctl;
  end

  for (genvar g = 0; g < ANGLE_ITERATIONS; g++) begin : g_cordic
    nlle_cordic_stage #(.Iter(g)) u_cordic (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cd_v[g]),
      .data_i  (cd_d[g]),
      .valid_o (cd_v[g+1]),
      .data_o  (cd_d[g+1])
    );
  end

  // quadrant fold
  always_comb begin
    a_lat = clamp_ang(cd_d[ANGLE_ITERATIONS].lat_a);
    a_lng = clamp_ang(cd_d[ANGLE_ITERATIONS].lng_a);
    priority if (!cd_d[ANGLE_ITERATIONS].ctl.xneg && !cd_d[ANGLE_ITERATIONS].ctl.yneg) begin
      f_lat_d = {2'b0, a_lat};
    end else if (cd_d[ANGLE_ITERATIONS].ctl.xneg && !cd_d[ANGLE_ITERATIONS].ctl.yneg) begin
      f_lat_d = (33'(1) << 31) - {2'b0, a_lat};
    end else if (cd_d[ANGLE_ITERATIONS].ctl.xneg) begin
      f_lat_d = (33'(1) << 31) + {2'b0, a_lat};
    end else begin
      f_lat_d = (33'(1) << 32) - {2'b0, a_lat};
    end
    f_lng_d = cd_d[ANGLE_ITERATIONS].ctl.zneg ? (32'(1) << 31) - {1'b0, a_lng}
                                              : {1'b0, a_lng};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_lat_q <= f_lat_d;
      f_lng_q <= f_lng_d;
      f_ctl_q <= cd_d[ANGLE_ITERATIONS].ctl;
    end
  end

  // byte scaling
  always_comb begin
    lat_prod   = {8'b0, f_lat_q} * 41'd255;
    lng_prod   = {9'b0, f_lng_q} * 41'd510;
    out_code_d = f_ctl_q.tiny ? 16'h0000 : {lat_prod[39:32], lng_prod[39:32]};
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_code_q <= out_code_d;
    end
  end

  assign out_o.valid          = out_v_q;
  assign out_o.encoded_normal = out_code_q;

  `NLLE_ASSERT_NXT(a_tiny_zero, f_v_q && f_ctl_q.tiny && en, out_code_q == 16'h0000)
  `NLLE_ASSERT_IMP(a_skid_on_stall, $rose(skid_v_q), $past(!en))
  `NLLE_ASSERT_IMP(a_lat_range, f_v_q, f_lat_q <= (33'(1) << 32))
  `NLLE_ASSERT_IMP(a_lng_range, f_v_q, f_lng_q <= (32'(1) << 31))
endmodule

[bench/nlle_checker.sv]
`timescale 1ns / 100ps

module nlle_checker (
  input  logic clk_i,
  input  logic rst_ni,
  nlle_in_if  vin,
  nlle_out_if vout,
  output int  fail_count_o,
  output int  pending_codes_o
);
  import nlle_pkg::*;

  localparam int FracBits   = 14;
  localparam int CordicSteps = 16;

  logic [15:0] code_q [$];
  int          fails;

  assign fail_count_o    = fails;
  assign pending_codes_o = code_q.size();

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned res, bitv;
    res  = 0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // first-quadrant vectoring, angle in turns * 2^32, clamped to a quarter turn
  function automatic longint unsigned quad_angle(longint xq, longint yq);
    longint cx, cy, ang, dx, dy;
    ang = 0;
    cx  = xq;
    cy  = yq;
    for (int i = 0; i < CordicSteps; i++) begin
      dx = cy >>> (i % 32);
      dy = cx >>> (i % 32);
      if (cy > 0) begin
        cx  = cx + dx;
        cy  = cy - dy;
        ang = ang + longint'(AtanTable[i % 32]);
      end else begin
        cx  = cx - dx;
        cy  = cy + dy;
        ang = ang - longint'(AtanTable[i % 32]);
      end
    end
    if (ang < 0) ang = 0;
    if (ang > (64'sd1 <<< 30)) ang = 64'sd1 <<< 30;
    return longint'(ang);
  endfunction

  function automatic logic [15:0] encode_normal(logic signed [15:0] nx, logic signed [15:0] ny,
                                                logic signed [15:0] nz);
    longint          x, y, z;
    longint unsigned sum, a, lat, lng, mz, s, lat8, lng8;
    x   = nx;
    y   = ny;
    z   = nz;
    sum = x * x + y * y + z * z;
    if (sum * 10000 < (64'd1 << (2 * FracBits))) return 16'h0000;
    a = quad_angle((x < 0 ? -x : x) <<< 15, (y < 0 ? -y : y) <<< 15);
    if (x >= 0 && y >= 0) lat = a;
    else if (x < 0 && y >= 0) lat = (64'd1 << 31) - a;
    else if (x < 0) lat = (64'd1 << 31) + a;
    else lat = (64'd1 << 32) - a;
    lat8 = ((lat * 255) >> 32) & 64'hff;
    mz = z < 0 ? -z : z;
    if (mz > (64'd1 << FracBits)) mz = 64'd1 << FracBits;
    mz = mz << (30 - FracBits);
    s = int_sqrt((64'd1 << 60) - mz * mz);
    a = quad_angle(longint'(mz), longint'(s));
    lng  = z < 0 ? (64'd1 << 31) - a : a;
    lng8 = ((lng * 510) >> 32) & 64'hff;
    return {lat8[7:0], lng8[7:0]};
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    $display("%0t: %s got %04h want %04h", $realtime, what, got, want);
    fails++;
  endtask

  initial fails = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (vin.valid && vin.ready)
        code_q.push_back(encode_normal(vin.norm_x, vin.norm_y, vin.norm_z));
      if (vout.valid && vout.ready) begin
        if (code_q.size() == 0) report_mismatch("unexpected beat", vout.encoded_normal, 16'h0);
        else if (vout.encoded_normal !== code_q[0])
          report_mismatch("encoded_normal", vout.encoded_normal, code_q.pop_front());
        else void'(code_q.pop_front());
      end
    end
  end
endmodule

[bench/tb.sv]
`timescale 1ns / 100ps

module tb;
  import nlle_pkg::*;

  localparam int RandomVectors = 850;
  localparam int CycleLimit    = 200000;
  localparam int DrainCycles   = 70;

  logic clk_i, rst_ni;
  int   fail_count, pending_codes, cycles;
  logic sink_hold;

  nlle_in_if  vin ();
  nlle_out_if vout ();

  normal_latlong_encoder uut (.clk_i(clk_i), .rst_ni(rst_ni), .in_i(vin), .out_o(vout));
  nlle_checker chk (.clk_i(clk_i), .rst_ni(rst_ni), .vin(vin), .vout(vout),
                    .fail_count_o(fail_count), .pending_codes_o(pending_codes));

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("tb failed");
        $finish;
      end
    end
  end

  // sink side: random stall per beat, with quiet stretches
  initial begin
    int wait_n;
    vout.ready <= 1'b0;
    sink_hold = 1'b0;
    @(posedge rst_ni);
    forever begin
      wait_n = sink_hold ? 0 : $urandom_range(0, 12);
      if (wait_n > 0) begin
        vout.ready <= 1'b0;
        repeat (wait_n) @(posedge clk_i);
      end
      vout.ready <= 1'b1;
      do @(posedge clk_i); while (!vout.valid);
      if ($urandom_range(0, 99) == 0) sink_hold = ~sink_hold;
    end
  end

  task automatic send_vector(logic signed [15:0] x, logic signed [15:0] y,
                             logic signed [15:0] z, int gap);
    if (gap > 0) begin
      vin.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    vin.valid  <= 1'b1;
    vin.norm_x <= x;
    vin.norm_y <= y;
    vin.norm_z <= z;
    do @(posedge clk_i); while (!vin.ready);
  endtask

  function automatic logic signed [15:0] rand_component(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 32768)) - 16384);
      2: return 16'($signed($urandom_range(0, 4)) - 2);
      default: return 16'($signed($urandom_range(0, 2)) * 16384 - 16384);
    endcase
  endfunction

  initial begin
    int mode, gap;
    logic signed [15:0] one;
    one = 16'sd16384;
    vin.valid  <= 1'b0;
    vin.norm_x <= '0;
    vin.norm_y <= '0;
    vin.norm_z <= '0;
    rst_ni = 1'b0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: extremes, axes, quadrant edges, clamped z, near-zero length
    send_vector(0, 0, 0, 0);
    send_vector(1, 1, 1, 1);
    send_vector(0, 0, 1, 0);
    send_vector(0, 0, 164, 0);
    send_vector(0, 0, 165, 0);
    send_vector(one, 0, 0, 2);
    send_vector(-one, 0, 0, 0);
    send_vector(0, one, 0, 0);
    send_vector(0, -one, 0, 0);
    send_vector(0, 0, one, 0);
    send_vector(0, 0, -one, 3);
    send_vector(0, 0, 16'sh7fff, 0);
    send_vector(0, 0, -16'sh8000, 0);
    send_vector(16'sh7fff, 16'sh7fff, 16'sh7fff, 0);
    send_vector(-16'sh8000, -16'sh8000, -16'sh8000, 0);
    send_vector(-16'sh8000, 16'sh7fff, 0, 0);
    send_vector(16'sh7fff, -16'sh8000, 0, 0);
    send_vector(16'sh7fff, -1, 0, 0);
    send_vector(-16'sh8000, -1, 5000, 0);
    send_vector(-one, 1, -5000, 0);
    send_vector(100, 100, -100, 0);
    send_vector(16'sh5555, 16'shaaaa, 16'sh2aaa, 0);
    for (int i = 0; i < RandomVectors; i++) begin
      mode = $urandom_range(0, 3);
      gap  = ((i / 100) % 2 == 1) ? 0 : $urandom_range(0, 12);
      send_vector(rand_component(mode), rand_component(mode), rand_component(mode), gap);
    end
    vin.valid <= 1'b0;
    while (pending_codes != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/nlle_pkg.sv
rtl/core/nlle_in_if.sv
rtl/core/nlle_out_if.sv
rtl/core/nlle_sqrt_stage.sv
rtl/core/nlle_cordic_stage.sv
rtl/core/normal_latlong_encoder.sv
bench/nlle_checker.sv
bench/tb.sv
